// ===== design/smed_pkg.sv =====
// Shared types and constants for the sliding window median filter.
`timescale 1ns / 1ps

package smed_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned CFG_W          = 7;
  localparam int unsigned OUT_W          = DATA_W + 1;
  localparam int unsigned MAX_WINDOW_DEF = 64;

  // One slot of the sorted chain: sample, age in items, occupied flag.
  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic [CFG_W-1:0]  age;
    logic              occ;
  } cell_t;

endpackage

// ===== design/smed_cell.sv =====
// One slot of the sorted sample chain: drop-out compaction and in-order insert.
`timescale 1ns / 1ps

module smed_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          clr_i,
  input  logic                          start_i,
  input  logic [smed_pkg::DATA_W-1:0]   sample_i,
  input  logic                          full_i,
  input  logic [smed_pkg::CFG_W-1:0]    k_m1_i,
  input  logic [smed_pkg::DATA_W-1:0]   old_val_i,
  input  smed_pkg::cell_t               right_i,
  input  logic                          right_g_i,
  input  smed_pkg::cell_t               left_c_i,
  input  logic                          left_gc_i,
  output smed_pkg::cell_t               state_o,
  output logic                          g_o,
  output smed_pkg::cell_t               c_o,
  output logic                          gc_o,
  output logic                          is_old_o,
  output logic [smed_pkg::DATA_W-1:0]   old_o
);
  import smed_pkg::*;

  logic [DATA_W-1:0] val_q, val_d;
  logic [CFG_W-1:0]  age_q, age_d;
  logic              occ_q, occ_d;
  logic              occ_eff, right_occ, rm;
  cell_t             c;

  // Occupancy as seen by this request; a start empties the window first.
  assign occ_eff   = occ_q && !start_i;
  assign right_occ = right_i.occ && !start_i;

  // Empty slots compare as +inf.
  assign g_o = !occ_eff || ($signed(val_q) > $signed(sample_i));

  // Equal samples sit oldest first, so the first slot at or above the
  // leaving value is the one that leaves.
  assign rm = occ_eff && full_i && ($signed(val_q) >= $signed(old_val_i));

  always_comb begin
    if (rm) begin
      c.val = right_i.val;
      c.age = right_i.age;
      c.occ = right_occ;
    end else begin
      c.val = val_q;
      c.age = age_q;
      c.occ = occ_eff;
    end
  end

  assign c_o  = c;
  assign gc_o = rm ? right_g_i : g_o;

  assign is_old_o = occ_eff && full_i && (age_q == k_m1_i);
  assign old_o    = is_old_o ? val_q : '0;

  always_comb begin
    if (left_gc_i) begin
      val_d = left_c_i.val;
      age_d = left_c_i.age + CFG_W'(1);
      occ_d = left_c_i.occ;
    end else if (gc_o) begin
      val_d = sample_i;
      age_d = '0;
      occ_d = 1'b1;
    end else begin
      val_d = c.val;
      age_d = c.age + CFG_W'(1);
      occ_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (clr_i) begin
      occ_q <= 1'b0;
    end else if (en_i) begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign state_o.val = val_q;
  assign state_o.age = age_q;
  assign state_o.occ = occ_q;

endmodule

// ===== design/sliding_window_median.sv =====
// Sliding window median filter: sorted cell chain, median pick and output register.
//
//   channel   signals                                    role
//   in        in_valid_i/in_ready_o, sample_i, start_req_i  sample requests
//   out       out_valid_o/out_ready_i, median_doubled_o     doubled median results
//   cfg       cfg_we_i, cfg_wdata_i                      window size write
//
// One request per cycle while in_ready_o is high; all cells update together.
// A result waits in the chain, flagged by pend_q, then loads into median_q.
// in_ready_o drops only while a result waits in the chain and the output is stalled.
// Reset (async, active low) empties the chain and sets the window size to 3.
// A window size write empties the chain; an accepted start request restarts it.
`timescale 1ns / 1ps

module sliding_window_median #(
  parameter int unsigned MAX_WINDOW = smed_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [smed_pkg::DATA_W-1:0]  sample_i,
  input  logic                                start_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [smed_pkg::OUT_W-1:0]   median_doubled_o,
  input  logic                                cfg_we_i,
  input  logic [smed_pkg::CFG_W-1:0]          cfg_wdata_i
);
  import smed_pkg::*;

  logic [CFG_W-1:0]  ws_q;
  logic [CFG_W-1:0]  k_eff, k_m1, lo_idx, hi_idx;
  logic [CFG_W-1:0]  fill_q, fill_d, fill_eff;
  logic              full, produce, acc, start;
  logic              pend_q, pend_d, ld;
  logic              out_valid_q;
  logic [OUT_W-1:0]  median_q, median_d;
  logic [DATA_W-1:0] old_val, lo_val, hi_val;

  cell_t             st [MAX_WINDOW];
  cell_t             cv [MAX_WINDOW];
  logic [DATA_W-1:0] old_part [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] g, gc, is_old, occ_v, lo_sel, hi_sel;

  // Effective window size: zero acts as one, saturates at MAX_WINDOW.
  always_comb begin
    if (ws_q == '0) begin
      k_eff = CFG_W'(1);
    end else if (32'(ws_q) > MAX_WINDOW) begin
      k_eff = CFG_W'(MAX_WINDOW);
    end else begin
      k_eff = ws_q;
    end
  end

  assign k_m1   = k_eff - CFG_W'(1);
  assign lo_idx = k_m1 >> 1;
  assign hi_idx = k_eff >> 1;

  assign acc      = in_valid_i && in_ready_o;
  assign start    = start_req_i;
  assign fill_eff = start ? '0 : fill_q;
  assign full     = (fill_eff == k_eff);
  assign fill_d   = full ? fill_eff : fill_eff + CFG_W'(1);
  assign produce  = (fill_d == k_eff);

  always_comb begin
    old_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      old_val = old_val | old_part[i];
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_chain
    cell_t right_s, left_s;
    logic  right_g, left_g;

    if (i == MAX_WINDOW - 1) begin : g_top
      assign right_s = '0;
      assign right_g = 1'b1;
    end else begin : g_mid
      assign right_s = st[i+1];
      assign right_g = g[i+1];
    end

    if (i == 0) begin : g_bot
      assign left_s = '0;
      assign left_g = 1'b0;
    end else begin : g_up
      assign left_s = cv[i-1];
      assign left_g = gc[i-1];
    end

    smed_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (acc),
      .clr_i     (cfg_we_i),
      .start_i   (start),
      .sample_i  (sample_i),
      .full_i    (full),
      .k_m1_i    (k_m1),
      .old_val_i (old_val),
      .right_i   (right_s),
      .right_g_i (right_g),
      .left_c_i  (left_s),
      .left_gc_i (left_g),
      .state_o   (st[i]),
      .g_o       (g[i]),
      .c_o       (cv[i]),
      .gc_o      (gc[i]),
      .is_old_o  (is_old[i]),
      .old_o     (old_part[i])
    );

    assign occ_v[i]  = st[i].occ;
    assign lo_sel[i] = (32'(lo_idx) == i);
    assign hi_sel[i] = (32'(hi_idx) == i);
  end

  // Middle pair of the sorted chain; the same slot twice for odd sizes.
  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      lo_val = lo_val | (lo_sel[i] ? st[i].val : '0);
      hi_val = hi_val | (hi_sel[i] ? st[i].val : '0);
    end
  end

  assign median_d = {lo_val[DATA_W-1], lo_val} + {hi_val[DATA_W-1], hi_val};

  assign ld         = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || !out_valid_q || out_ready_i;

  always_comb begin
    if (acc) begin
      pend_d = produce;
    end else if (ld) begin
      pend_d = 1'b0;
    end else begin
      pend_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= CFG_W'(3);
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (cfg_we_i) begin
        ws_q   <= cfg_wdata_i;
        fill_q <= '0;
      end else if (acc) begin
        fill_q <= fill_d;
      end
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      median_q <= median_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = median_q;

  a_fill_le_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= k_eff)
    else $error("fill count above window size");

  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_v) == 32'(fill_q))
    else $error("occupied cells disagree with fill count");

  a_one_old: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(is_old))
    else $error("more than one oldest cell");

  a_full_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && full && !cfg_we_i) |=> pend_q)
    else $error("full window request gave no result");

endmodule
